>>> hdl/ppi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_pkg: shared types, constants and helpers
// Pool geometry, pooled particle record, sequencer states and the
// saturating adders used by the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_EMIT   = 2'd0,
        OP_TICK   = 2'd1,
        OP_RENDER = 2'd2
    } ppi_op_t;

    localparam logic [1:0] KIND_EMIT = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_DRAW = 2'd2;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [23:0] vel_x;
        logic [23:0] vel_y;
        logic [23:0] life;
        logic [23:0] max_life;
        logic [15:0] gravity;
        logic [7:0]  size;
        logic [31:0] rgba;
    } ppi_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ppi_div_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT_ACK,
        S_T_RD,
        S_T_LIFE,
        S_T_MOVE_RD,
        S_T_MOVE_WR,
        S_T_VY,
        S_T_PX,
        S_T_PY,
        S_T_DONE,
        S_R_RD,
        S_R_MUL,
        S_R_DIV,
        S_R_OUT
    } ppi_state_t;

    // Velocity plus a floor-scaled increment, saturated to 24 signed bits.
    function automatic logic [23:0] add_sat24(logic [23:0] v, logic [29:0] d);
        logic [30:0] s;
        s = {{7{v[23]}}, v} + {d[29], d};
        if (s[30:23] == {8{s[30]}})
            return s[23:0];
        return s[30] ? 24'h800000 : 24'h7FFFFF;
    endfunction

    // Position plus a floor-scaled increment, saturated to 32 signed bits.
    function automatic logic [31:0] add_sat32(logic [31:0] v, logic [25:0] d);
        logic [32:0] s;
        s = {v[31], v} + {{7{d[25]}}, d};
        if (s[32] == s[31])
            return s[31:0];
        return s[32] ? 32'h80000000 : 32'h7FFFFFFF;
    endfunction

    // Position minus half the Q4.4 size, saturated to 32 signed bits.
    function automatic logic [31:0] sub_half_sat32(logic [31:0] v, logic [7:0] size);
        logic [32:0] s;
        s = {v[31], v} - {22'd0, size, 3'd0};
        if (s[32] == s[31])
            return s[31:0];
        return s[32] ? 32'h80000000 : 32'h7FFFFFFF;
    endfunction

endpackage
`default_nettype wire

>>> hdl/ppi_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_mul: shared registered multiplier
// Signed 25 by 17 bit product, registered, shared by every update step.
// ----------------------------------------------------------------------------
module ppi_mul
    import ppi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [24:0] op_a,
    input  wire logic signed [16:0] op_b,
    output logic signed [41:0]      product
);

    logic signed [41:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule
`default_nettype wire

>>> hdl/ppi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppi_div: iterative alpha divider
// Restoring division giving an 8-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module ppi_div
    import ppi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [23:0] den,
    output logic [7:0]       quotient,
    output ppi_div_status_t  status
);

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [23:0] den_reg, den_next;
    logic [7:0]  q_reg, q_next;
    logic [31:0] trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        trial     = {8'd0, den_reg} << cnt_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            cnt_next  = 3'd7;
            rem_next  = num;
            den_next  = den;
            q_next    = 8'd0;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next         = rem_reg - trial;
                q_next[cnt_reg]  = 1'b1;
            end
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quotient    = q_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

>>> hdl/particle_pool_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_integrator: dense fixed-point particle pool
// Emit, tick and render over a swap-remove pool of up to POOL_DEPTH particles.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_stall) carries one command per transaction:
// emit a particle, advance time by time_step, or render the pool. The output
// channel (out_valid/out_stall) returns one acknowledge transaction for emit
// and tick, and one draw transaction per pooled particle for render, with
// last set on the final one. Unused operation codes are dropped silently.
// The block takes one command at a time; in_stall stays high until every
// result of the current command has been placed in the output register.
// Emit writes the particle as the command is taken, then acknowledges it.
// A tick makes three passes through the single shared multiplier for each
// surviving particle, and fills the slot of a removed particle with the
// last pooled one. Render forms each alpha with the restoring divider.
// Reset empties the pool; pool storage itself is not cleared, since only
// slots below the live count are ever read. When the receiver stalls, the
// result stays in the output register and the sequencer waits in place
// whenever it has a further result to load.
// ----------------------------------------------------------------------------
module particle_pool_integrator
    import ppi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [23:0] vel_x,
    input  wire logic [23:0] vel_y,
    input  wire logic [23:0] life,
    input  wire logic [15:0] gravity,
    input  wire logic [7:0]  size,
    input  wire logic [31:0] color_rgba,
    input  wire logic [15:0] time_step,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [31:0]      draw_x,
    output logic [31:0]      draw_y,
    output logic [7:0]       draw_size,
    output logic [23:0]      color_rgb,
    output logic [7:0]       alpha,
    output logic [6:0]       live_count,
    output logic             dropped,
    output logic             last
);

    // Pool memory: one write port, one registered read port.
    ppi_entry_t mem [POOL_DEPTH];
    ppi_entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    ppi_entry_t       wr_data;
    logic             wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer and working registers.
    ppi_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      dt_reg, dt_next;
    logic             drop_reg, drop_next;
    ppi_entry_t       ent_reg, ent_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg;
    logic [31:0] dx_reg;
    logic [31:0] dy_reg;
    logic [7:0]  dsize_reg;
    logic [23:0] rgb_reg;
    logic [7:0]  alpha_reg;
    logic [6:0]  live_reg;
    logic        dropped_reg;
    logic        last_reg;

    logic        out_free;
    logic        out_load;
    logic [1:0]  ld_kind;
    logic [31:0] ld_dx;
    logic [31:0] ld_dy;
    logic [7:0]  ld_size;
    logic [23:0] ld_rgb;
    logic [7:0]  ld_alpha;
    logic [CNT_W-1:0] ld_live;
    logic        ld_dropped;
    logic        ld_last;

    // Shared multiplier and divider.
    logic signed [24:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [41:0] mul_p;
    logic               div_start;
    logic [7:0]         div_q;
    ppi_div_status_t    div_st;

    // The divider is started in the cycle after the multiplier operands are set,
    // from the registered product, and its done flag is cleared by the start, so each particle gets a fresh quotient.
    logic div_armed_reg, div_armed_next;

    logic [23:0]      life_new;
    logic [23:0]      life_min;
    logic             full;
    logic [CNT_W-1:0] idx_inc;

    ppi_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    ppi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (mul_p[31:0]),
        .den      (ent_reg.max_life),
        .quotient (div_q),
        .status   (div_st)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign full     = (count_reg >= CNT_W'(POOL_DEPTH));
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign life_new = (rd_data_reg.life > {8'd0, dt_reg})
                      ? rd_data_reg.life - {8'd0, dt_reg} : 24'd0;
    assign life_min = (ent_reg.life > ent_reg.max_life) ? ent_reg.max_life : ent_reg.life;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        dt_next    = dt_reg;
        drop_next  = drop_reg;
        ent_next   = ent_reg;
        in_stall   = 1'b1;
        rd_addr    = idx_reg[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = idx_reg[IDX_W-1:0];
        wr_data    = ent_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        ld_kind    = KIND_EMIT;
        ld_dx      = '0;
        ld_dy      = '0;
        ld_size    = '0;
        ld_rgb     = '0;
        ld_alpha   = '0;
        ld_live    = count_reg;
        ld_dropped = 1'b0;
        ld_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dt_next  = time_step;
                    idx_next = '0;
                    case (operation)
                        OP_EMIT:
                        begin
                            drop_next = full;
                            if (!full)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = count_reg[IDX_W-1:0];
                                wr_data = '{pos_x: pos_x, pos_y: pos_y,
                                            vel_x: vel_x, vel_y: vel_y,
                                            life: life, max_life: life,
                                            gravity: gravity, size: size,
                                            rgba: color_rgba};
                                count_next = count_reg + CNT_W'(1);
                            end
                            state_next = S_EMIT_ACK;
                        end
                        OP_TICK:
                            state_next = (time_step == 16'd0) ? S_T_DONE : S_T_RD;
                        OP_RENDER:
                            state_next = (count_reg == '0) ? S_IDLE : S_R_RD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_EMIT_ACK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = KIND_EMIT;
                    ld_dropped = drop_reg;
                    state_next = S_IDLE;
                end
            end
            S_T_RD:
            begin
                state_next = (idx_reg >= count_reg) ? S_T_DONE : S_T_LIFE;
            end
            S_T_LIFE:
            begin
                ent_next      = rd_data_reg;
                ent_next.life = life_new;
                mul_a         = {{9{rd_data_reg.gravity[15]}}, rd_data_reg.gravity};
                mul_b         = {1'b0, dt_reg};
                if (life_new == 24'd0)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_T_MOVE_RD;
                end
                else
                    state_next = S_T_VY;
            end
            S_T_MOVE_RD:
            begin
                rd_addr    = count_reg[IDX_W-1:0];
                state_next = S_T_MOVE_WR;
            end
            S_T_MOVE_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data_reg;
                state_next = S_T_RD;
            end
            S_T_VY:
            begin
                ent_next.vel_y = add_sat24(ent_reg.vel_y, mul_p[41:12]);
                mul_a          = {ent_reg.vel_x[23], ent_reg.vel_x};
                mul_b          = {1'b0, dt_reg};
                state_next     = S_T_PX;
            end
            S_T_PX:
            begin
                ent_next.pos_x = add_sat32(ent_reg.pos_x, mul_p[41:16]);
                mul_a          = {ent_reg.vel_y[23], ent_reg.vel_y};
                mul_b          = {1'b0, dt_reg};
                state_next     = S_T_PY;
            end
            S_T_PY:
            begin
                wr_en         = 1'b1;
                wr_data       = ent_reg;
                wr_data.pos_y = add_sat32(ent_reg.pos_y, mul_p[41:16]);
                idx_next      = idx_inc;
                state_next    = S_T_RD;
            end
            S_T_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = KIND_TICK;
                    state_next = S_IDLE;
                end
            end
            S_R_RD:
            begin
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                ent_next   = rd_data_reg;
                state_next = S_R_DIV;
            end
            S_R_DIV:
            begin
                // Product of clamped life and colour alpha feeds the divider.
                mul_a      = {1'b0, life_min};
                mul_b      = {9'd0, ent_reg.rgba[7:0]};
                state_next = S_R_OUT;
            end
            S_R_OUT:
            begin
                if (div_armed_reg)
                    div_start = 1'b1;
                else if (!div_st.busy && div_st.done && out_free)
                begin
                    out_load = 1'b1;
                    ld_kind  = KIND_DRAW;
                    ld_dx    = sub_half_sat32(ent_reg.pos_x, ent_reg.size);
                    ld_dy    = sub_half_sat32(ent_reg.pos_y, ent_reg.size);
                    ld_size  = ent_reg.size;
                    ld_rgb   = ent_reg.rgba[31:8];
                    ld_alpha = (ent_reg.max_life == 24'd0) ? 8'd0 : div_q;
                    ld_last  = (idx_inc == count_reg);
                    idx_next = idx_inc;
                    state_next = (idx_inc == count_reg) ? S_IDLE : S_R_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign div_armed_next = (state_reg == S_R_DIV) ? 1'b1
                            : (div_start ? 1'b0 : div_armed_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_armed_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            div_armed_reg <= div_armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        drop_reg <= drop_next;
        ent_reg  <= ent_next;
        if (out_load)
        begin
            kind_reg    <= ld_kind;
            dx_reg      <= ld_dx;
            dy_reg      <= ld_dy;
            dsize_reg   <= ld_size;
            rgb_reg     <= ld_rgb;
            alpha_reg   <= ld_alpha;
            live_reg    <= 7'(ld_live);
            dropped_reg <= ld_dropped;
            last_reg    <= ld_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign draw_x      = dx_reg;
    assign draw_y      = dy_reg;
    assign draw_size   = dsize_reg;
    assign color_rgb   = rgb_reg;
    assign alpha       = alpha_reg;
    assign live_count  = live_reg;
    assign dropped     = dropped_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_DEPTH))
        else $error("pool count exceeds pool depth");

    a_tick_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_RD) |-> (idx_reg <= count_reg))
        else $error("tick index ran past the live count");

    a_render_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_RD) |-> (idx_reg < count_reg))
        else $error("render reads a slot outside the pool");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a stalled transaction");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> div_armed_reg)
        else $error("divider started without a fresh product");
`endif

endmodule
`default_nettype wire
